@@ design/vxf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vxf_pkg
// Types and helpers shared by the vertex transform pipeline.
// ----------------------------------------------------------------------------
package vxf_pkg;

  localparam int NUM_REGS = 8;
  localparam int IDX_W    = 8;
  localparam int SUM_W    = 66;   // rounded row sum
  localparam int NUM_W    = 90;   // |N| << FRAC_BITS at the widest fraction
  localparam int REM_W    = 67;
  localparam int QUO_W    = 33;

  localparam logic [63:0] COL0_ROWS01_RST = 64'h0000_0000_0001_0000;
  localparam logic [63:0] COL0_ROWS23_RST = 64'h0;
  localparam logic [63:0] COL1_ROWS01_RST = 64'h0001_0000_0000_0000;
  localparam logic [63:0] COL1_ROWS23_RST = 64'h0;
  localparam logic [63:0] COL2_ROWS01_RST = 64'h0;
  localparam logic [63:0] COL2_ROWS23_RST = 64'h0000_0000_0001_0000;
  localparam logic [63:0] COL3_ROWS01_RST = 64'h0;
  localparam logic [63:0] COL3_ROWS23_RST = 64'h0001_0000_0000_0000;

  localparam logic OP_VECTOR = 1'b0;
  localparam logic OP_POINT  = 1'b1;

  typedef logic [NUM_REGS-1:0][63:0] mat_t;

  typedef struct packed {
    logic        operation;
    logic [31:0] in_x;
    logic [31:0] in_y;
    logic [31:0] in_z;
    logic [31:0] in_w;
  } in_t;

  typedef struct packed {
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic [31:0] out_w;
    logic        divide_by_zero;
    logic        saturated;
  } out_t;

  typedef struct packed {
    logic                  op;
    logic [3:0][SUM_W-1:0] n;
  } dot_t;

  typedef struct packed {
    logic                  op;
    logic                  dz;
    logic                  sat0;
    logic [3:0][31:0]      vec;
    logic [2:0]            neg;
    logic [2:0]            big;
    logic [SUM_W-1:0]      ad;
    logic [2:0][REM_W-1:0] rem;
    logic [2:0][NUM_W-1:0] num;
    logic [2:0][QUO_W-1:0] quo;
  } dv_t;

  function automatic logic [32:0] sat32(logic [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] s;
    s = $signed(v);
    if (s > $signed(SUM_W'(64'sd2147483647))) begin
      return {1'b1, 32'h7fff_ffff};
    end else if (s < $signed(-SUM_W'(64'sd2147483648))) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b0, v[31:0]};
  endfunction

endpackage

@@ design/homogeneous_vertex_transform_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform_unit
// 4x4 fixed-point matrix transform with optional perspective divide.
//
//   channel  dir   handshake              word
//   in       in    in_valid / in_ready    in_data   (vxf_pkg::in_t)
//   out      out   out_valid / out_ready  out_data  (vxf_pkg::out_t)
//   cfg      in    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word per cycle while the output is not stalled. Stages: input register,
// multiply, pair add, sum and round, divide setup, 33 divider steps (one
// quotient bit each), output register. The divider depth sets the latency.
// Reset clears all valid bits and loads the identity matrix.
// Each stage holds while the stage after it is full and stalled; empty
// stages keep filling, so a stalled output does not block input at once.
// ----------------------------------------------------------------------------
module homogeneous_vertex_transform_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  vxf_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output vxf_pkg::out_t              out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [vxf_pkg::IDX_W-1:0]  cfg_index,
  input  logic [63:0]                cfg_data
);
  import vxf_pkg::*;

  localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

  mat_t  mat;
  dot_t  dot_d;
  logic  dot_v, dot_rdy;
  dv_t   dv_d;
  logic  dv_v, dv_rdy;
  out_t  o_next;
  logic  big [3];
  logic  [31:0] mag [3];
  logic  [31:0] res [3];
  logic  sat [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mat[0] <= COL0_ROWS01_RST;
      mat[1] <= COL0_ROWS23_RST;
      mat[2] <= COL1_ROWS01_RST;
      mat[3] <= COL1_ROWS23_RST;
      mat[4] <= COL2_ROWS01_RST;
      mat[5] <= COL2_ROWS23_RST;
      mat[6] <= COL3_ROWS01_RST;
      mat[7] <= COL3_ROWS23_RST;
    end else if (cfg_valid && cfg_index < IDX_W'(NUM_REGS)) begin
      mat[cfg_index[2:0]] <= cfg_data;
    end
  end

  vxf_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
    .clk     (clk),
    .rst     (rst),
    .mat     (mat),
    .in_d    (in_data),
    .in_v    (in_valid),
    .in_rdy  (in_ready),
    .out_d   (dot_d),
    .out_v   (dot_v),
    .out_rdy (dot_rdy)
  );

  vxf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk     (clk),
    .rst     (rst),
    .in_d    (dot_d),
    .in_v    (dot_v),
    .in_rdy  (dot_rdy),
    .out_d   (dv_d),
    .out_v   (dv_v),
    .out_rdy (dv_rdy)
  );

  assign dv_rdy = !out_valid || out_ready;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      big[i] = dv_d.big[i] | dv_d.quo[i][QUO_W-1];
      mag[i] = dv_d.quo[i][31:0];
      if (!dv_d.neg[i]) begin
        sat[i] = big[i] | mag[i][31];
        res[i] = sat[i] ? 32'h7fff_ffff : mag[i];
      end else begin
        sat[i] = big[i] | (mag[i] > 32'h8000_0000);
        res[i] = sat[i] ? 32'h8000_0000 : 32'(-mag[i]);
      end
    end
    if (dv_d.op == OP_VECTOR) begin
      o_next.out_x          = dv_d.vec[0];
      o_next.out_y          = dv_d.vec[1];
      o_next.out_z          = dv_d.vec[2];
      o_next.out_w          = dv_d.vec[3];
      o_next.divide_by_zero = 1'b0;
      o_next.saturated      = dv_d.sat0;
    end else if (dv_d.dz) begin
      o_next                = '0;
      o_next.divide_by_zero = 1'b1;
    end else begin
      o_next.out_x          = res[0];
      o_next.out_y          = res[1];
      o_next.out_z          = res[2];
      o_next.out_w          = ONE;
      o_next.divide_by_zero = 1'b0;
      o_next.saturated      = sat[0] | sat[1] | sat[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dv_rdy) begin
      out_valid <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (dv_rdy) out_data <= o_next;
  end

endmodule

@@ design/vxf_dot.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vxf_dot
// Four row dot products: input register, multiply, pair add, sum and round.
// ----------------------------------------------------------------------------
module vxf_dot #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  vxf_pkg::mat_t   mat,
  input  vxf_pkg::in_t    in_d,
  input  logic            in_v,
  output logic            in_rdy,
  output vxf_pkg::dot_t   out_d,
  output logic            out_v,
  input  logic            out_rdy
);
  import vxf_pkg::*;

  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);
  localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

  logic                   a_v, b_v, c_v;
  logic                   a_op, b_op, c_op;
  logic [3:0][31:0]       a_vec;
  logic [3:0][3:0][63:0]  b_prod, b_prod_next;
  logic [3:0][1:0][64:0]  c_pair, c_pair_next;
  dot_t                   d_next;
  logic signed [SUM_W-1:0] tsum [4];
  logic                   en_a, en_b, en_c, en_d;

  assign en_d   = !out_v || out_rdy;
  assign en_c   = !c_v || en_d;
  assign en_b   = !b_v || en_c;
  assign en_a   = !a_v || en_b;
  assign in_rdy = en_a;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        b_prod_next[r][c] = $signed(mat[c * 2 + r / 2][(r % 2) * 32 +: 32]) *
                            $signed(a_vec[c]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int h = 0; h < 2; h++) begin
        c_pair_next[r][h] = {b_prod[r][2*h][63], b_prod[r][2*h]} +
                            {b_prod[r][2*h+1][63], b_prod[r][2*h+1]};
      end
    end
  end

  always_comb begin
    d_next.op = c_op;
    for (int r = 0; r < 4; r++) begin
      tsum[r] = $signed({c_pair[r][0][64], c_pair[r][0]}) +
                $signed({c_pair[r][1][64], c_pair[r][1]}) + HALF;
      d_next.n[r] = tsum[r] >>> FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v   <= 1'b0;
      b_v   <= 1'b0;
      c_v   <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (en_a) a_v <= in_v;
      if (en_b) b_v <= a_v;
      if (en_c) c_v <= b_v;
      if (en_d) out_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_op     <= in_d.operation;
      a_vec[0] <= in_d.in_x;
      a_vec[1] <= in_d.in_y;
      a_vec[2] <= in_d.in_z;
      a_vec[3] <= (in_d.operation == OP_POINT) ? ONE : in_d.in_w;
    end
    if (en_b) begin
      b_op   <= a_op;
      b_prod <= b_prod_next;
    end
    if (en_c) begin
      c_op   <= b_op;
      c_pair <= c_pair_next;
    end
    if (en_d) out_d <= d_next;
  end

endmodule

@@ design/vxf_div_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vxf_div_step
// One restoring division step: one quotient bit for each of x, y and z.
// ----------------------------------------------------------------------------
module vxf_div_step #(
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  vxf_pkg::dv_t  in_d,
  input  logic          in_v,
  output logic          in_rdy,
  output vxf_pkg::dv_t  out_d,
  output logic          out_v,
  input  logic          out_rdy
);
  import vxf_pkg::*;

  dv_t              d_next;
  logic [REM_W-1:0] r2 [3];
  logic [REM_W-1:0] den;
  logic             ge [3];

  assign in_rdy = !out_v || out_rdy;
  assign den    = {1'b0, in_d.ad};

  always_comb begin
    d_next = in_d;
    for (int i = 0; i < 3; i++) begin
      r2[i] = {in_d.rem[i][REM_W-2:0], in_d.num[i][BIT]};
      ge[i] = r2[i] >= den;
      d_next.rem[i] = ge[i] ? r2[i] - den : r2[i];
      d_next.quo[i] = {in_d.quo[i][QUO_W-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (in_rdy) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy) out_d <= d_next;
  end

endmodule

@@ design/vxf_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vxf_div
// Perspective divide: setup stage and a 33-step pipelined divider.
// ----------------------------------------------------------------------------
module vxf_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  vxf_pkg::dot_t in_d,
  input  logic          in_v,
  output logic          in_rdy,
  output vxf_pkg::dv_t  out_d,
  output logic          out_v,
  input  logic          out_rdy
);
  import vxf_pkg::*;

  dv_t              p_next;
  dv_t              st_d   [QUO_W+1];
  logic             st_v   [QUO_W+1];
  logic             st_rdy [QUO_W+1];
  logic [SUM_W-1:0] an     [3];
  logic [NUM_W-1:0] xh     [3];
  logic [32:0]      s0     [4];
  logic             en_p;

  assign en_p   = !st_v[0] || st_rdy[0];
  assign in_rdy = en_p;

  always_comb begin
    p_next     = '0;
    p_next.op  = in_d.op;
    p_next.dz  = (in_d.op == OP_POINT) && (in_d.n[3] == '0);
    p_next.ad  = in_d.n[3][SUM_W-1] ? SUM_W'(-in_d.n[3]) : in_d.n[3];
    for (int r = 0; r < 4; r++) begin
      s0[r]         = sat32(in_d.n[r]);
      p_next.vec[r] = s0[r][31:0];
    end
    p_next.sat0 = s0[0][32] | s0[1][32] | s0[2][32] | s0[3][32];
    for (int i = 0; i < 3; i++) begin
      an[i]            = in_d.n[i][SUM_W-1] ? SUM_W'(-in_d.n[i]) : in_d.n[i];
      p_next.neg[i]    = in_d.n[i][SUM_W-1] ^ in_d.n[3][SUM_W-1];
      p_next.num[i]    = NUM_W'(an[i]) << FRAC_BITS;
      xh[i]            = p_next.num[i] >> QUO_W;
      p_next.big[i]    = xh[i] >= NUM_W'(p_next.ad);
      p_next.rem[i]    = REM_W'(xh[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_v[0] <= 1'b0;
    end else if (en_p) begin
      st_v[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en_p) st_d[0] <= p_next;
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    vxf_div_step #(.BIT(QUO_W - 1 - k)) u_step (
      .clk     (clk),
      .rst     (rst),
      .in_d    (st_d[k]),
      .in_v    (st_v[k]),
      .in_rdy  (st_rdy[k]),
      .out_d   (st_d[k+1]),
      .out_v   (st_v[k+1]),
      .out_rdy (st_rdy[k+1])
    );
  end

  assign st_rdy[QUO_W] = out_rdy;
  assign out_d         = st_d[QUO_W];
  assign out_v         = st_v[QUO_W];

endmodule

@@ design/vxf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vxf_checker
// Port-level checks for the vertex transform unit.
// ----------------------------------------------------------------------------
module vxf_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input vxf_pkg::out_t              out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.divide_by_zero |->
      out_data.out_x == 32'h0 && out_data.out_y == 32'h0 &&
      out_data.out_z == 32'h0 && out_data.out_w == 32'h0 && !out_data.saturated)
    else $error("zero denominator word is not all zero");

  a_empty_ready: assert property (@(posedge clk)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind homogeneous_vertex_transform_unit vxf_checker u_vxf_checker (.*);
